/* rtl/hcbd_pkg.sv */
// shared types, constants and byte classification for the chunked body decoder
`timescale 1ns / 1ps
package hcbd_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int Q_DEPTH     = 2;
  localparam int Q_PTR_W     = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

  localparam logic [1:0] ST_BUSY = 2'd0;
  localparam logic [1:0] ST_OK   = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic [1:0] status;
  } out_t;

  // pre-decoded request passed from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       is_hex;
    logic [3:0] hex_val;
    logic       is_cr;
    logic       is_lf;
    logic       is_blank;
  } cls_t;

  function automatic cls_t classify(input in_t item);
    cls_t c;
    logic [7:0] b;
    b         = item.in_byte;
    c.data    = b;
    c.last    = item.in_last;
    c.is_cr   = (b == CH_CR);
    c.is_lf   = (b == CH_LF);
    c.is_blank = (b == CH_SPACE) || (b == CH_TAB);
    c.is_hex  = 1'b1;
    c.hex_val = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      c.hex_val = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      c.hex_val = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      c.hex_val = 4'(b - 8'h37);
    end else begin
      c.is_hex = 1'b0;
    end
    return c;
  endfunction

endpackage

/* rtl/hcbd_front.sv */
// front stage: takes input requests and classifies each byte
`timescale 1ns / 1ps
module hcbd_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  hcbd_pkg::in_t  in_item,
  output logic           full,
  input  logic           q_full,
  output logic           q_wr,
  output hcbd_pkg::cls_t q_data
);

  logic           fv;
  hcbd_pkg::cls_t fcls;
  logic           load;

  assign full   = fv && q_full;
  assign load   = !fv || !q_full;
  assign q_wr   = fv && !q_full;
  assign q_data = fcls;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (load) begin
      fv <= push;
    end
    if (load && push) begin
      fcls <= hcbd_pkg::classify(in_item);
    end
  end

endmodule

/* rtl/hcbd_queue.sv */
// short queue of classified requests between front and back
`timescale 1ns / 1ps
module hcbd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  hcbd_pkg::cls_t wr_data,
  output logic           q_full,
  input  logic           rd,
  output hcbd_pkg::cls_t rd_data,
  output logic           q_empty
);

  hcbd_pkg::cls_t                       mem [hcbd_pkg::Q_DEPTH];
  logic [hcbd_pkg::Q_PTR_W-1:0]         wptr;
  logic [hcbd_pkg::Q_PTR_W-1:0]         rptr;
  logic [hcbd_pkg::Q_CNT_W-1:0]         count;
  logic                                 do_wr;
  logic                                 do_rd;

  assign q_full  = (count == hcbd_pkg::Q_CNT_W'(hcbd_pkg::Q_DEPTH));
  assign q_empty = (count == '0);
  assign do_wr   = wr && !q_full;
  assign do_rd   = rd && !q_empty;
  assign rd_data = mem[rptr];

  function automatic logic [hcbd_pkg::Q_PTR_W-1:0] bump(
      input logic [hcbd_pkg::Q_PTR_W-1:0] p);
    logic [hcbd_pkg::Q_PTR_W-1:0] r;
    if (p == hcbd_pkg::Q_PTR_W'(hcbd_pkg::Q_DEPTH - 1)) r = '0;
    else r = p + 1'b1;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) wptr <= bump(wptr);
      if (do_rd) rptr <= bump(rptr);
      if (do_wr && !do_rd) count <= count + 1'b1;
      else if (do_rd && !do_wr) count <= count - 1'b1;
    end
    if (do_wr) begin
      mem[wptr] <= wr_data;
    end
  end

endmodule

/* rtl/hcbd_back.sv */
// back stage: chunk framing state machine and result register
`timescale 1ns / 1ps
module hcbd_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  hcbd_pkg::cls_t q_data,
  output logic           q_rd,
  input  logic           pop,
  output logic           empty,
  output hcbd_pkg::out_t out_item
);

  localparam int CW = hcbd_pkg::COUNT_WIDTH;

  typedef enum logic [2:0] {
    PH_LINE_START,
    PH_SIZE,
    PH_DATA,
    PH_TRAIL_CR,
    PH_TRAIL_LF,
    PH_DONE
  } phase_t;

  phase_t          phase, phase_next;
  logic [CW-1:0]   left, left_next;
  logic            seen, seen_next;
  logic            ended, ended_next;
  logic            crp, crp_next;
  logic [1:0]      fstat, fstat_next;
  logic            ovalid;
  logic [7:0]      ob;
  logic            ov;
  logic            go;

  assign go    = !q_empty && (!ovalid || pop);
  assign q_rd  = go;
  assign empty = !ovalid;

  always_comb begin
    logic in_line;
    logic restart;
    phase_next = phase;
    left_next  = left;
    seen_next  = seen;
    ended_next = ended;
    crp_next   = crp;
    fstat_next = fstat;
    ob         = 8'd0;
    ov         = 1'b0;
    in_line    = 1'b0;
    restart    = 1'b0;

    unique case (phase)
      PH_LINE_START: restart = 1'b1;
      PH_SIZE:       in_line = 1'b1;
      PH_DATA: begin
        ob        = q_data.data;
        ov        = 1'b1;
        left_next = left - 1'b1;
        if (left == CW'(1)) phase_next = PH_TRAIL_CR;
      end
      PH_TRAIL_CR: begin
        if (q_data.is_cr) phase_next = PH_TRAIL_LF;
        else restart = 1'b1;
      end
      PH_TRAIL_LF: begin
        if (q_data.is_lf) phase_next = PH_LINE_START;
        else restart = 1'b1;
      end
      PH_DONE: ;
      default: ;
    endcase

    // a bare cr after data opens a size line that already saw its cr
    if (restart) begin
      in_line    = 1'b1;
      phase_next = PH_SIZE;
      left_next  = '0;
      seen_next  = 1'b0;
      ended_next = (phase == PH_TRAIL_LF);
      crp_next   = (phase == PH_TRAIL_LF);
    end

    if (in_line) begin
      if (crp_next && q_data.is_lf) begin
        crp_next = 1'b0;
        if (!seen_next) begin
          fstat_next = hcbd_pkg::ST_ERR;
          phase_next = PH_DONE;
        end else if (left_next == '0) begin
          fstat_next = hcbd_pkg::ST_OK;
          phase_next = PH_DONE;
        end else begin
          phase_next = PH_DATA;
        end
      end else begin
        crp_next = q_data.is_cr;
        if (q_data.is_cr) begin
          ended_next = 1'b1;
        end else if (!ended_next && !(!seen_next && q_data.is_blank)) begin
          if (!q_data.is_hex) begin
            ended_next = 1'b1;
          end else if (left_next[CW-1 -: 4] != 4'd0) begin
            fstat_next = hcbd_pkg::ST_ERR;
            phase_next = PH_DONE;
          end else begin
            left_next = {left_next[CW-5:0], q_data.hex_val};
            seen_next = 1'b1;
          end
        end
      end
    end

    if (q_data.last && phase_next != PH_DONE) begin
      if (phase_next == PH_LINE_START || phase_next == PH_TRAIL_CR)
        fstat_next = hcbd_pkg::ST_OK;
      else
        fstat_next = hcbd_pkg::ST_ERR;
      phase_next = PH_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_LINE_START;
      left   <= '0;
      seen   <= 1'b0;
      ended  <= 1'b0;
      crp    <= 1'b0;
      fstat  <= hcbd_pkg::ST_BUSY;
      ovalid <= 1'b0;
    end else begin
      if (go) begin
        phase  <= phase_next;
        left   <= left_next;
        seen   <= seen_next;
        ended  <= ended_next;
        crp    <= crp_next;
        fstat  <= fstat_next;
        ovalid <= 1'b1;
      end else if (pop) begin
        ovalid <= 1'b0;
      end
    end
    if (go) begin
      out_item.out_byte  <= ob;
      out_item.out_valid <= ov;
      out_item.status    <= fstat_next;
    end
  end

endmodule

/* rtl/http_chunked_body_decoder_core.sv */
// top level of the http chunked body decoder
`timescale 1ns / 1ps
//
// channel   dir  handshake              payload
// input     in   push / full            in_item  (in_byte, in_last)
// result    out  pop / empty            out_item (out_byte, out_valid, status)
//
// one byte per clock sustained while results are popped; every accepted byte yields exactly one result
// a request reaches the ports through the classify register, which loads at the
// accepting edge, then a queue entry, then the result register
// the framing state machine in the back stage updates once per byte
// rst is synchronous, active high, and clears all control state; no clearing pass
// a stalled result side fills the result register, then the queue and the front
// register, then raises full
//
module http_chunked_body_decoder_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  hcbd_pkg::in_t  in_item,
  input  logic           pop,
  output logic           empty,
  output hcbd_pkg::out_t out_item
);

  // front to queue
  logic           q_wr;
  hcbd_pkg::cls_t q_wdata;
  logic           q_full;

  // queue to back
  logic           q_rd;
  hcbd_pkg::cls_t q_rdata;
  logic           q_empty;

  // front: classify each byte (hex value, cr, lf, blank) into a register
  hcbd_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .in_item (in_item),
    .full    (full),
    .q_full  (q_full),
    .q_wr    (q_wr),
    .q_data  (q_wdata)
  );

  // two-entry queue decoupling front and back stalls
  hcbd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .wr_data (q_wdata),
    .q_full  (q_full),
    .rd      (q_rd),
    .rd_data (q_rdata),
    .q_empty (q_empty)
  );

  // back: size line parse, data pass-through, trailer and end handling
  hcbd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_data   (q_rdata),
    .q_rd     (q_rd),
    .pop      (pop),
    .empty    (empty),
    .out_item (out_item)
  );

`ifndef NO_ASSERTIONS
  // queue cannot be both full and empty
  a_queue_sane: assert property (@(posedge clk) disable iff (rst)
    !(q_full && q_empty))
    else $error("queue full and empty at once");

  // input backpressure only arises when the queue is full
  a_full_cause: assert property (@(posedge clk) disable iff (rst)
    full |-> q_full)
    else $error("full raised with room in queue");

  // non-payload results carry a zero byte
  a_zero_byte: assert property (@(posedge clk) disable iff (rst)
    (!empty && !out_item.out_valid) |-> (out_item.out_byte == 8'd0))
    else $error("non-payload result with nonzero byte");

  // a pending result with no pop keeps the queue from draining into it
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |-> !q_rd)
    else $error("queue read while result stalled");
`endif

endmodule
